// File: rtl/sha1s_pkg.sv
package sha1s_pkg;

    localparam int unsigned NumChain = 5;
    localparam int unsigned NumWords = 16;
    localparam int unsigned NumRounds = 80;

    localparam logic [31:0] IV0 = 32'h6745_2301;
    localparam logic [31:0] IV1 = 32'hefcd_ab89;
    localparam logic [31:0] IV2 = 32'h98ba_dcfe;
    localparam logic [31:0] IV3 = 32'h1032_5476;
    localparam logic [31:0] IV4 = 32'hc3d2_e1f0;

    localparam logic [31:0] RK0 = 32'h5a82_7999;
    localparam logic [31:0] RK1 = 32'h6ed9_eba1;
    localparam logic [31:0] RK2 = 32'h8f1b_bcdc;
    localparam logic [31:0] RK3 = 32'hca62_c1d6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [0:0] CMD_ABSORB = 1'b0;
    localparam logic [0:0] CMD_FINISH = 1'b1;

    // last byte index that still leaves room for the length in the same block
    localparam logic [5:0] LAST_FIT_POS = 6'd55;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;

    typedef logic [NumChain-1:0][31:0] t_chain;

    typedef enum logic [1:0] {
        GRP_CH,
        GRP_PAR1,
        GRP_MAJ,
        GRP_PAR2
    } t_grp;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } t_core_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FIN1,
        S_FIN2_LD,
        S_FIN2,
        S_EMIT
    } t_top_st;

    // commands from the sequencer to the compression core
    typedef struct packed {
        logic        wr;        // store one message byte
        logic        pad;       // apply the end-of-message mask at pos
        logic        pad_len;   // also drop the bit length into words 14 and 15
        logic        zero_len;  // load an all-zero block carrying the bit length
        logic        start;     // begin 80 rounds on the current block
        logic        init;      // return chaining words to the initial values
        logic [5:0]  pos;
        logic [7:0]  data;
        logic [31:0] len_hi;
        logic [31:0] len_lo;
    } t_core_cmd;

    function automatic logic [31:0] sha1s_rotl1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] sha1s_rotl5(input logic [31:0] v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] sha1s_rotl30(input logic [31:0] v);
        return {v[1:0], v[31:2]};
    endfunction

    function automatic logic [31:0] sha1s_f(input t_grp g, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        case (g)
            GRP_CH:  res = d ^ (b & (c ^ d));
            GRP_MAJ: res = (b & c) | (d & (b | c));
            default: res = b ^ c ^ d;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] sha1s_k(input t_grp g);
        logic [31:0] res;
        case (g)
            GRP_CH:   res = RK0;
            GRP_PAR1: res = RK1;
            GRP_MAJ:  res = RK2;
            default:  res = RK3;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/sha1s_core.sv
module sha1s_core
    import sha1s_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_cmd i_cmd,
    output logic      o_done,
    output t_chain    o_chain
);

    t_core_st          r_state, n_state;
    logic [6:0]        r_round;
    logic [31:0]       r_w [NumWords];
    logic [31:0]       n_w [NumWords];
    logic [31:0]       r_a, r_b, r_c, r_d, r_e;
    t_chain            r_h;
    t_grp              w_grp;
    logic [31:0]       w_new;
    logic [31:0]       w_tmp;
    logic [5:0]        w_bi;

    // round group from the round counter
    always_comb begin
        if (r_round < 7'd20) begin
            w_grp = GRP_CH;
        end else if (r_round < 7'd40) begin
            w_grp = GRP_PAR1;
        end else if (r_round < 7'd60) begin
            w_grp = GRP_MAJ;
        end else begin
            w_grp = GRP_PAR2;
        end
    end

    assign w_new = sha1s_rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);
    assign w_tmp = sha1s_rotl5(r_a) + sha1s_f(w_grp, r_b, r_c, r_d) + r_e
                   + sha1s_k(w_grp) + r_w[0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE:  if (i_cmd.start) n_state = C_ROUND;
            C_ROUND: if (r_round == 7'(NumRounds - 1)) n_state = C_ADD;
            C_ADD:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = 1'b0;
        case (r_state)
            C_ADD:   o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    assign o_chain = r_h;

    // message window: byte writes, padding and the zero-length block outside the rounds, shift during rounds
    always_comb begin
        w_bi = '0;
        for (int i = 0; i < NumWords; i++) begin
            n_w[i] = r_w[i];
        end
        if (r_state == C_ROUND) begin
            for (int i = 0; i < NumWords - 1; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[NumWords-1] = w_new;
        end else if (i_cmd.wr) begin
            n_w[i_cmd.pos[5:2]][{~i_cmd.pos[1:0], 3'b000} +: 8] = i_cmd.data;
        end else if (i_cmd.zero_len) begin
            for (int i = 0; i < NumWords; i++) begin
                n_w[i] = '0;
            end
            n_w[14] = i_cmd.len_hi;
            n_w[15] = i_cmd.len_lo;
        end else if (i_cmd.pad) begin
            for (int i = 0; i < 64; i++) begin
                w_bi = 6'(i);
                if (w_bi == i_cmd.pos) begin
                    n_w[i/4][(3 - (i % 4)) * 8 +: 8] = PAD_MARK;
                end else if (w_bi > i_cmd.pos) begin
                    n_w[i/4][(3 - (i % 4)) * 8 +: 8] = 8'h00;
                end
            end
            if (i_cmd.pad_len) begin
                n_w[14] = i_cmd.len_hi;
                n_w[15] = i_cmd.len_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NumWords; i++) begin
            r_w[i] <= n_w[i];
        end
        case (r_state)
            C_IDLE: begin
                r_a     <= r_h[0];
                r_b     <= r_h[1];
                r_c     <= r_h[2];
                r_d     <= r_h[3];
                r_e     <= r_h[4];
            end
            C_ROUND: begin
                r_a <= w_tmp;
                r_b <= r_a;
                r_c <= sha1s_rotl30(r_b);
                r_d <= r_c;
                r_e <= r_d;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_h     <= {IV4, IV3, IV2, IV1, IV0};
        end else begin
            r_state <= n_state;
            if (r_state == C_ROUND) begin
                r_round <= r_round + 7'd1;
            end else begin
                r_round <= '0;
            end
            if (r_state == C_ADD) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else if (i_cmd.init) begin
                r_h <= {IV4, IV3, IV2, IV1, IV0};
            end
        end
    end

endmodule

// File: rtl/sha1_stream_hasher_top.sv
// Absorb: bytes are taken while idle; the 64th byte of a block starts compression
// (80 rounds plus a chaining add), and no byte is taken until it has ended.
// Finish: one padding block is compressed, or two when the length does not fit
// behind the pad mark, then five digest words go out, h0 first; the next message
// may start while the last word waits. Reset (i_rst_n low, synchronous): chaining
// words to the initial values, counts cleared, output empty.
module sha1_stream_hasher_top
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);

    t_top_st     r_state, n_state;
    logic [5:0]  r_count;        // byte position in the current block
    logic [31:0] r_blocks;       // compressed blocks, wraps modulo 2^32
    logic [2:0]  r_out_idx;      // next digest word to load
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_last;

    t_core_cmd   w_cmd;
    logic        w_core_done;
    t_chain      w_chain;
    logic        w_accept;
    logic        w_fits;
    logic        w_out_free;
    logic        w_load;

    sha1s_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_done  (w_core_done),
        .o_chain (w_chain)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign w_accept      = i_valid && o_ready;
    // length fits behind the pad mark in this block
    assign w_fits        = (r_count <= LAST_FIT_POS);
    assign w_out_free    = !r_out_valid || i_ready;
    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_digest_last = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_FINISH) begin
                        n_state = S_FIN1;
                    end else if (r_count == LAST_BYTE_POS) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN:     if (w_core_done) n_state = S_IDLE;
            S_FIN1:    if (w_core_done) n_state = w_fits ? S_EMIT : S_FIN2_LD;
            S_FIN2_LD: n_state = S_FIN2;
            S_FIN2:    if (w_core_done) n_state = S_EMIT;
            S_EMIT:    if (w_out_free && r_out_idx == 3'(NumChain - 1)) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs: commands to the core and digest word loads
    always_comb begin
        w_cmd          = '0;
        w_cmd.pos      = r_count;
        w_cmd.data     = i_data_byte;
        // bit length = blocks * 512 + bytes * 8, 64 bits big-endian
        w_cmd.len_hi   = {23'd0, r_blocks[31:23]};
        w_cmd.len_lo   = {r_blocks[22:0], r_count, 3'b000};
        w_load         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_FINISH) begin
                        w_cmd.pad     = 1'b1;
                        w_cmd.pad_len = w_fits;
                        w_cmd.start   = 1'b1;
                    end else begin
                        w_cmd.wr    = 1'b1;
                        w_cmd.start = (r_count == LAST_BYTE_POS);
                    end
                end
            end
            S_FIN2_LD: begin
                w_cmd.zero_len = 1'b1;
                w_cmd.start    = 1'b1;
            end
            S_EMIT: begin
                w_load = w_out_free;
                // reinit as the last word is loaded into the output register
                w_cmd.init = w_out_free && (r_out_idx == 3'(NumChain - 1));
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word <= w_chain[r_out_idx];
            r_out_last <= (r_out_idx == 3'(NumChain - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_blocks    <= '0;
            r_out_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance byte count; block counter steps when a block fills
            if (w_accept && i_command == CMD_ABSORB) begin
                r_count <= r_count + 6'd1;
                if (r_count == LAST_BYTE_POS) begin
                    r_blocks <= r_blocks + 32'd1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_out_idx == 3'(NumChain - 1)) begin
                    r_out_idx <= '0;
                    r_count   <= '0;
                    r_blocks  <= '0;
                end else begin
                    r_out_idx <= r_out_idx + 3'd1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
